FILE: rtl/lpci_pkg.sv
// lpci_pkg: widths, relation codes and pipeline structs for the line pair
// classify and intersect block
// no dependencies

package lpci_pkg;

   localparam int CW    = 16;               // input coordinate width
   localparam int FRAC  = 16;               // fraction bits of the crossing point
   localparam int QW    = 48;               // output coordinate width
   localparam int DW    = CW + 1;           // direction and offset vectors
   localparam int PRW   = 2 * DW;           // 17x17 products
   localparam int PW    = PRW + 1;          // cross products (den, tn)
   localparam int NUMW  = CW + PW + 2;      // crossing numerator
   localparam int NSW   = NUMW + FRAC + 1;  // scaled numerator with rounding term
   localparam int DDW   = PW + 1;           // doubled divisor
   localparam int DIVW  = DDW + QW;         // divider remainder width
   localparam int NCELL = QW;               // one quotient bit per cell

   typedef enum logic [1:0] {
      REL_COINCIDE  = 2'd0,
      REL_PARALLEL  = 2'd1,
      REL_INTERSECT = 2'd2
   } rel_type;

   typedef struct packed {
      rel_type relation;
      logic    perp;
      logic    isect;
      logic    degen;
      logic    negx;
      logic    negy;
      logic    ovfx;
      logic    ovfy;
   } meta_type;

   typedef struct packed {
      meta_type          meta;
      logic [DIVW-1:0]   rx;
      logic [DIVW-1:0]   ry;
      logic [DIVW-1:0]   ds;
      logic [QW-1:0]     qx;
      logic [QW-1:0]     qy;
   } div_type;

endpackage

FILE: rtl/lpci_if.sv
// lpci_req_if and lpci_rsp_if: valid/ready channels carrying a line pair
// and its classification result; depends on lpci_pkg

interface lpci_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [lpci_pkg::CW-1:0]  l1_ax;
   logic signed [lpci_pkg::CW-1:0]  l1_ay;
   logic signed [lpci_pkg::CW-1:0]  l1_bx;
   logic signed [lpci_pkg::CW-1:0]  l1_by;
   logic signed [lpci_pkg::CW-1:0]  l2_ax;
   logic signed [lpci_pkg::CW-1:0]  l2_ay;
   logic signed [lpci_pkg::CW-1:0]  l2_bx;
   logic signed [lpci_pkg::CW-1:0]  l2_by;

   modport source (output valid, l1_ax, l1_ay, l1_bx, l1_by, l2_ax, l2_ay, l2_bx, l2_by,
                   input ready);
   modport sink   (input valid, l1_ax, l1_ay, l1_bx, l1_by, l2_ax, l2_ay, l2_bx, l2_by,
                   output ready);
endinterface

interface lpci_rsp_if;
   logic                            valid;
   logic                            ready;
   lpci_pkg::rel_type               relation;
   logic                            perpendicular;
   logic signed [lpci_pkg::QW-1:0]  cross_x;
   logic signed [lpci_pkg::QW-1:0]  cross_y;
   logic                            saturated;
   logic                            degenerate;

   modport source (output valid, relation, perpendicular, cross_x, cross_y, saturated,
                   degenerate, input ready);
   modport sink   (input valid, relation, perpendicular, cross_x, cross_y, saturated,
                   degenerate, output ready);
endinterface

FILE: rtl/lpci_front.sv
// lpci_front: eight stage elastic pipeline that forms cross and dot products,
// classifies the pair and prepares dividend and divisor for the divider chain
// depends on lpci_pkg and lpci_req_if

module lpci_front (
   input  logic               clock,
   input  logic               reset,
   lpci_req_if.sink           req_chan,
   output logic               out_valid,
   output lpci_pkg::div_type  out_data,
   input  logic               out_ready
);

   localparam int NST = 8;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] rdy;

   // stage 0
   logic signed [lpci_pkg::DW-1:0] d1x0_ff, d1y0_ff, d2x0_ff, d2y0_ff, ex0_ff, ey0_ff;
   logic signed [lpci_pkg::CW-1:0] a1x0_ff, a1y0_ff;
   // stage 1
   logic signed [lpci_pkg::PRW-1:0] pda1_ff, pdb1_ff, pta1_ff, ptb1_ff;
   logic signed [lpci_pkg::PRW-1:0] pca1_ff, pcb1_ff, poa1_ff, pob1_ff;
   logic                            deg1_1_ff, deg2_1_ff, epz1_ff;
   logic signed [lpci_pkg::CW-1:0]  a1x1_ff, a1y1_ff;
   logic signed [lpci_pkg::DW-1:0]  d1x1_ff, d1y1_ff;
   // stage 2
   logic signed [lpci_pkg::PW-1:0]  den2_ff, tn2_ff;
   lpci_pkg::meta_type              meta2_ff, meta2_in;
   logic signed [lpci_pkg::CW-1:0]  a1x2_ff, a1y2_ff;
   logic signed [lpci_pkg::DW-1:0]  d1x2_ff, d1y2_ff;
   logic signed [lpci_pkg::PW-1:0]  den2_in, tn2_in, dot2;
   logic                            tnz2, cpz2;
   // stage 3
   logic signed [lpci_pkg::NUMW-1:0] mxa3_ff, mxb3_ff, mya3_ff, myb3_ff;
   logic signed [lpci_pkg::PW-1:0]   den3_ff;
   lpci_pkg::meta_type               meta3_ff;
   // stage 4
   logic signed [lpci_pkg::NUMW-1:0] numx4_ff, numy4_ff;
   logic signed [lpci_pkg::PW-1:0]   den4_ff;
   lpci_pkg::meta_type               meta4_ff;
   // stage 5
   logic [lpci_pkg::NUMW-1:0]        magx5_ff, magy5_ff;
   logic [lpci_pkg::PW-1:0]          dmag5_ff;
   lpci_pkg::meta_type               meta5_ff, meta5_in;
   // stage 6
   logic [lpci_pkg::NSW-1:0]         nx6_ff, ny6_ff;
   logic [lpci_pkg::DDW-1:0]         dd6_ff;
   lpci_pkg::meta_type               meta6_ff;
   // stage 7
   lpci_pkg::div_type                out_ff, out_in;
   logic [lpci_pkg::DIVW-1:0]        dtop7;

   always_comb begin
      rdy[NST-1] = !v_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_chan.ready = rdy[0];
   assign out_valid      = v_ff[NST-1];
   assign out_data       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 2 classification
   always_comb begin
      den2_in = lpci_pkg::PW'(pda1_ff) - lpci_pkg::PW'(pdb1_ff);
      tn2_in  = lpci_pkg::PW'(pta1_ff) - lpci_pkg::PW'(ptb1_ff);
      dot2    = lpci_pkg::PW'(poa1_ff) + lpci_pkg::PW'(pob1_ff);
      tnz2    = (pta1_ff == ptb1_ff);
      cpz2    = (pca1_ff == pcb1_ff);
      meta2_in = '0;
      meta2_in.degen = deg1_1_ff || deg2_1_ff;
      priority if (deg1_1_ff && deg2_1_ff) begin
         meta2_in.relation = epz1_ff ? lpci_pkg::REL_COINCIDE : lpci_pkg::REL_PARALLEL;
      end else if (deg1_1_ff) begin
         meta2_in.relation = tnz2 ? lpci_pkg::REL_COINCIDE : lpci_pkg::REL_PARALLEL;
      end else if (deg2_1_ff) begin
         meta2_in.relation = cpz2 ? lpci_pkg::REL_COINCIDE : lpci_pkg::REL_PARALLEL;
      end else begin
         meta2_in.perp = (dot2 == '0);
         if (pda1_ff != pdb1_ff) begin
            meta2_in.relation = lpci_pkg::REL_INTERSECT;
            meta2_in.isect    = 1'b1;
         end else begin
            meta2_in.relation = cpz2 ? lpci_pkg::REL_COINCIDE : lpci_pkg::REL_PARALLEL;
         end
      end
   end

   always_comb begin
      meta5_in      = meta4_ff;
      meta5_in.negx = numx4_ff[lpci_pkg::NUMW-1] ^ den4_ff[lpci_pkg::PW-1];
      meta5_in.negy = numy4_ff[lpci_pkg::NUMW-1] ^ den4_ff[lpci_pkg::PW-1];
   end

   // overflow when the quotient would need more than QW bits
   always_comb begin
      dtop7          = {dd6_ff, {lpci_pkg::QW{1'b0}}};
      out_in         = '0;
      out_in.meta    = meta6_ff;
      out_in.rx      = lpci_pkg::DIVW'(nx6_ff);
      out_in.ry      = lpci_pkg::DIVW'(ny6_ff);
      out_in.ds      = dtop7 >> 1;
      out_in.meta.ovfx = (lpci_pkg::DIVW'(nx6_ff) >= dtop7);
      out_in.meta.ovfy = (lpci_pkg::DIVW'(ny6_ff) >= dtop7);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a1x0_ff <= req_chan.l1_ax;
         a1y0_ff <= req_chan.l1_ay;
         d1x0_ff <= lpci_pkg::DW'(req_chan.l1_bx) - lpci_pkg::DW'(req_chan.l1_ax);
         d1y0_ff <= lpci_pkg::DW'(req_chan.l1_by) - lpci_pkg::DW'(req_chan.l1_ay);
         d2x0_ff <= lpci_pkg::DW'(req_chan.l2_bx) - lpci_pkg::DW'(req_chan.l2_ax);
         d2y0_ff <= lpci_pkg::DW'(req_chan.l2_by) - lpci_pkg::DW'(req_chan.l2_ay);
         ex0_ff  <= lpci_pkg::DW'(req_chan.l2_ax) - lpci_pkg::DW'(req_chan.l1_ax);
         ey0_ff  <= lpci_pkg::DW'(req_chan.l2_ay) - lpci_pkg::DW'(req_chan.l1_ay);
      end
      if (rdy[1]) begin
         pda1_ff   <= lpci_pkg::PRW'(d1x0_ff) * lpci_pkg::PRW'(d2y0_ff);
         pdb1_ff   <= lpci_pkg::PRW'(d1y0_ff) * lpci_pkg::PRW'(d2x0_ff);
         pta1_ff   <= lpci_pkg::PRW'(ex0_ff) * lpci_pkg::PRW'(d2y0_ff);
         ptb1_ff   <= lpci_pkg::PRW'(ey0_ff) * lpci_pkg::PRW'(d2x0_ff);
         pca1_ff   <= lpci_pkg::PRW'(ex0_ff) * lpci_pkg::PRW'(d1y0_ff);
         pcb1_ff   <= lpci_pkg::PRW'(ey0_ff) * lpci_pkg::PRW'(d1x0_ff);
         poa1_ff   <= lpci_pkg::PRW'(d1x0_ff) * lpci_pkg::PRW'(d2x0_ff);
         pob1_ff   <= lpci_pkg::PRW'(d1y0_ff) * lpci_pkg::PRW'(d2y0_ff);
         deg1_1_ff <= (d1x0_ff == '0) && (d1y0_ff == '0);
         deg2_1_ff <= (d2x0_ff == '0) && (d2y0_ff == '0);
         epz1_ff   <= (ex0_ff == '0) && (ey0_ff == '0);
         a1x1_ff   <= a1x0_ff;
         a1y1_ff   <= a1y0_ff;
         d1x1_ff   <= d1x0_ff;
         d1y1_ff   <= d1y0_ff;
      end
      if (rdy[2]) begin
         den2_ff  <= den2_in;
         tn2_ff   <= tn2_in;
         meta2_ff <= meta2_in;
         a1x2_ff  <= a1x1_ff;
         a1y2_ff  <= a1y1_ff;
         d1x2_ff  <= d1x1_ff;
         d1y2_ff  <= d1y1_ff;
      end
      if (rdy[3]) begin
         mxa3_ff  <= lpci_pkg::NUMW'(a1x2_ff) * lpci_pkg::NUMW'(den2_ff);
         mxb3_ff  <= lpci_pkg::NUMW'(d1x2_ff) * lpci_pkg::NUMW'(tn2_ff);
         mya3_ff  <= lpci_pkg::NUMW'(a1y2_ff) * lpci_pkg::NUMW'(den2_ff);
         myb3_ff  <= lpci_pkg::NUMW'(d1y2_ff) * lpci_pkg::NUMW'(tn2_ff);
         den3_ff  <= den2_ff;
         meta3_ff <= meta2_ff;
      end
      if (rdy[4]) begin
         numx4_ff <= mxa3_ff + mxb3_ff;
         numy4_ff <= mya3_ff + myb3_ff;
         den4_ff  <= den3_ff;
         meta4_ff <= meta3_ff;
      end
      if (rdy[5]) begin
         magx5_ff <= numx4_ff[lpci_pkg::NUMW-1] ? lpci_pkg::NUMW'(-numx4_ff)
                                                 : lpci_pkg::NUMW'(numx4_ff);
         magy5_ff <= numy4_ff[lpci_pkg::NUMW-1] ? lpci_pkg::NUMW'(-numy4_ff)
                                                 : lpci_pkg::NUMW'(numy4_ff);
         dmag5_ff <= den4_ff[lpci_pkg::PW-1] ? lpci_pkg::PW'(-den4_ff)
                                             : lpci_pkg::PW'(den4_ff);
         meta5_ff <= meta5_in;
      end
      if (rdy[6]) begin
         // round half away from zero: (2n*2^f + d) / 2d
         nx6_ff   <= {magx5_ff, {(lpci_pkg::FRAC + 1){1'b0}}} + lpci_pkg::NSW'(dmag5_ff);
         ny6_ff   <= {magy5_ff, {(lpci_pkg::FRAC + 1){1'b0}}} + lpci_pkg::NSW'(dmag5_ff);
         dd6_ff   <= {dmag5_ff, 1'b0};
         meta6_ff <= meta5_ff;
      end
      if (rdy[7]) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: rtl/lpci_div_cell.sv
// lpci_div_cell: one restoring division step for both coordinates, with its
// own valid/ready stage; depends on lpci_pkg

module lpci_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lpci_pkg::div_type  in_data,
   output logic               in_ready,
   output logic               out_valid,
   output lpci_pkg::div_type  out_data,
   input  logic               out_ready
);

   logic              valid_ff;
   lpci_pkg::div_type data_ff, data_in;
   logic [lpci_pkg::DIVW:0] tx, ty;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      tx      = {1'b0, in_data.rx} - {1'b0, in_data.ds};
      ty      = {1'b0, in_data.ry} - {1'b0, in_data.ds};
      data_in = in_data;
      data_in.ds = in_data.ds >> 1;
      data_in.qx = {in_data.qx[lpci_pkg::QW-2:0], !tx[lpci_pkg::DIVW]};
      data_in.qy = {in_data.qy[lpci_pkg::QW-2:0], !ty[lpci_pkg::DIVW]};
      if (!tx[lpci_pkg::DIVW]) begin
         data_in.rx = tx[lpci_pkg::DIVW-1:0];
      end
      if (!ty[lpci_pkg::DIVW]) begin
         data_in.ry = ty[lpci_pkg::DIVW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/line_pair_classify_intersect.sv
// Line pair classifier: takes two lines given by two 16-bit points each and
// returns coinciding, parallel or intersecting, a perpendicular flag, a
// degenerate flag and the crossing point in signed Q32.16, rounded half away
// from zero and saturated. One item per cycle is accepted unless the output
// stalls; items pass eight stages of products and sums, a chain of 48 divider
// cells each resolving one quotient bit for x and y, and the output register.
// Every stage stalls on its own, so bubbles close up behind a waiting result.
// depends on lpci_pkg, lpci_if, lpci_front, lpci_div_cell

module line_pair_classify_intersect (
   input  logic       clock,
   input  logic       reset,
   lpci_req_if.sink   req_chan,
   lpci_rsp_if.source rsp_chan
);

   logic              cell_valid [0:lpci_pkg::NCELL];
   logic              cell_ready [0:lpci_pkg::NCELL];
   lpci_pkg::div_type cell_data  [0:lpci_pkg::NCELL];

   logic              rsp_valid_ff;
   logic              last_ready;
   lpci_pkg::div_type fin;
   logic [lpci_pkg::QW-1:0] limx, limy, valx, valy;
   logic              satx, saty;

   lpci_pkg::rel_type       relation_ff;
   logic                    perp_ff, sat_ff, degen_ff;
   logic [lpci_pkg::QW-1:0] cross_x_ff, cross_y_ff, cross_x_in, cross_y_in;
   logic                    sat_in;

   lpci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (cell_valid[0]),
      .out_data  (cell_data[0]),
      .out_ready (cell_ready[0])
   );

   for (genvar i = 0; i < lpci_pkg::NCELL; i++) begin : g_cell
      lpci_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_data   (cell_data[i]),
         .in_ready  (cell_ready[i]),
         .out_valid (cell_valid[i+1]),
         .out_data  (cell_data[i+1]),
         .out_ready (cell_ready[i+1])
      );
   end

   assign last_ready                  = !rsp_valid_ff || rsp_chan.ready;
   assign cell_ready[lpci_pkg::NCELL] = last_ready;
   assign fin                         = cell_data[lpci_pkg::NCELL];

   // negative results may reach -2^47, positive ones 2^47-1
   always_comb begin
      limx = {1'b0, {(lpci_pkg::QW - 1){1'b1}}} + lpci_pkg::QW'(fin.meta.negx);
      limy = {1'b0, {(lpci_pkg::QW - 1){1'b1}}} + lpci_pkg::QW'(fin.meta.negy);
      satx = fin.meta.ovfx || (fin.qx > limx);
      saty = fin.meta.ovfy || (fin.qy > limy);
      valx = satx ? limx : fin.qx;
      valy = saty ? limy : fin.qy;
      cross_x_in = '0;
      cross_y_in = '0;
      sat_in     = 1'b0;
      if (fin.meta.isect) begin
         cross_x_in = fin.meta.negx ? lpci_pkg::QW'(-valx) : valx;
         cross_y_in = fin.meta.negy ? lpci_pkg::QW'(-valy) : valy;
         sat_in     = satx || saty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_ready) begin
         rsp_valid_ff <= cell_valid[lpci_pkg::NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (last_ready) begin
         relation_ff <= fin.meta.relation;
         perp_ff     <= fin.meta.perp;
         degen_ff    <= fin.meta.degen;
         sat_ff      <= sat_in;
         cross_x_ff  <= cross_x_in;
         cross_y_ff  <= cross_y_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.relation      = relation_ff;
   assign rsp_chan.perpendicular = perp_ff;
   assign rsp_chan.cross_x       = cross_x_ff;
   assign rsp_chan.cross_y       = cross_y_ff;
   assign rsp_chan.saturated     = sat_ff;
   assign rsp_chan.degenerate    = degen_ff;

endmodule

FILE: rtl/lpci_checker.sv
// lpci_checker: port level checks of the line pair classifier, bound to the
// top level; depends on lpci_pkg and lpci_if

module lpci_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        relation,
   input logic              perpendicular,
   input logic [lpci_pkg::QW-1:0] cross_x,
   input logic [lpci_pkg::QW-1:0] cross_y,
   input logic              saturated,
   input logic              degenerate
);

   localparam logic [1:0] ISECT = lpci_pkg::REL_INTERSECT;

   // a stalled item keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cross_x) && $stable(cross_y)
                                   && $stable(relation))
      else $error("rsp item changed while stalled");

   // no crossing point without an intersection
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && relation != ISECT |-> cross_x == '0 && cross_y == '0 && !saturated)
      else $error("crossing point on non-intersecting item");

   // a point line is never perpendicular nor crossing
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && degenerate |-> !perpendicular && relation != ISECT)
      else $error("degenerate item classified as crossing");

   // no item comes out right after reset
   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind line_pair_classify_intersect lpci_checker u_lpci_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .relation      (rsp_chan.relation),
   .perpendicular (rsp_chan.perpendicular),
   .cross_x       (rsp_chan.cross_x),
   .cross_y       (rsp_chan.cross_y),
   .saturated     (rsp_chan.saturated),
   .degenerate    (rsp_chan.degenerate)
);
